// File: rtl/core/cursor_line_edit_buffer_core_assert.svh
// assertion macros used by the port-level checker file
`ifndef CURSOR_LINE_EDIT_BUFFER_CORE_ASSERT_SVH
`define CURSOR_LINE_EDIT_BUFFER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle, checked outside reset
`define CLEB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle, checked outside reset
`define CLEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cleb_pkg.sv
// shared constants, codes and types of the line edit buffer
package cleb_pkg;

    // text storage
    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // word field widths
    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd0;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_INS   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGN  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    // memory work handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] JOB_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] JOB_MOVE_L = 3'd1;
    localparam logic [KIND_W-1:0] JOB_MOVE_R = 3'd2;
    localparam logic [KIND_W-1:0] JOB_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] JOB_READ_L = 3'd4;
    localparam logic [KIND_W-1:0] JOB_READ_R = 3'd5;

    // queue depths
    localparam int JQ_DEPTH  = 2;
    localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]    text_length;
        logic [CNT_W-1:0]    cursor_pos;
        logic [STATUS_W-1:0] status;
    } summary_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] ch;
        summary_t          summary;
    } job_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        summary_t          summary;
    } result_t;

endpackage

// File: rtl/core/cursor_line_edit_buffer_core.sv
// Single-line text buffer with a cursor, kept as a gap buffer of two 4096-byte
// stacks. Commands enter as queue words (push/full) and every command gives one
// result word (empty/pop) with the byte read, the length, the cursor position and
// a status. The front checks boundaries and updates the stack depths in the cycle
// a word is accepted, so up to two of its commands can wait in the job queue for
// the back. The back handles one command at a time: a registered stack read as the
// job starts, then the stack write and the result in the EXEC state; it starts no
// new command until that one is done and a result slot is free. Stack contents are
// not cleared at reset and need no clearing pass.
module cursor_line_edit_buffer_core
    import cleb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [OP_W-1:0]     opcode,
    input  logic [CHAR_W-1:0]   char_in,
    input  logic [INDEX_W-1:0]  read_index,
    output logic                empty,
    input  logic                pop,
    output logic [CHAR_W-1:0]   char_out,
    output logic [CNT_W-1:0]    text_length,
    output logic [CNT_W-1:0]    cursor_pos,
    output logic [STATUS_W-1:0] status
);

    logic accept;
    job_t front_job;
    job_t back_job;
    logic jq_empty;
    logic jq_pop;

    assign accept = push && !full;

    // decode and bookkeeping
    cleb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .char_in    (char_in),
        .read_index (read_index),
        .job        (front_job)
    );

    // job queue between the two halves
    cleb_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .job_in  (front_job),
        .full    (full),
        .pop     (jq_pop),
        .job_out (back_job),
        .empty   (jq_empty)
    );

    // memories and results
    cleb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_in      (back_job),
        .job_empty   (jq_empty),
        .job_pop     (jq_pop),
        .pop         (pop),
        .empty       (empty),
        .char_out    (char_out),
        .text_length (text_length),
        .cursor_pos  (cursor_pos),
        .status      (status)
    );

endmodule

// File: rtl/core/cleb_job_queue.sv
// short queue of memory jobs between the front and the back
module cleb_job_queue
    import cleb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    output logic full,
    input  logic pop,
    output job_t job_out,
    output logic empty
);

    job_t                slot_reg [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg;
    logic [JQ_PTR_W-1:0] wr_ptr_next;
    logic [JQ_PTR_W-1:0] rd_ptr_reg;
    logic [JQ_PTR_W-1:0] rd_ptr_next;
    logic [JQ_CNT_W-1:0] count_reg;
    logic [JQ_CNT_W-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == JQ_CNT_W'(JQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// File: rtl/core/cleb_front.sv
// command decode, boundary checks and cursor bookkeeping
module cleb_front
    import cleb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [OP_W-1:0]    opcode,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic [INDEX_W-1:0] read_index,
    output job_t               job
);

    logic [CNT_W-1:0] left_count_reg;
    logic [CNT_W-1:0] left_count_next;
    logic [CNT_W-1:0] right_count_reg;
    logic [CNT_W-1:0] right_count_next;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] right_pos;
    logic [CNT_W-1:0] left_top;
    logic [CNT_W-1:0] right_top;

    assign len       = left_count_reg + right_count_reg;
    assign idx_ext   = CNT_W'(read_index);
    assign cap       = CNT_W'(CAPACITY);
    assign right_pos = len - CNT_W'(1) - idx_ext;
    assign left_top  = left_count_reg - CNT_W'(1);
    assign right_top = right_count_reg - CNT_W'(1);

    // classify the command and work out the new counts
    always_comb
    begin
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        job.kind         = JOB_NONE;
        job.rd_addr      = '0;
        job.wr_addr      = '0;
        job.ch           = char_in;
        job.summary.status = STAT_DONE;
        unique case (opcode)
            OP_LEFT:
            begin
                if (left_count_reg == '0 || right_count_reg >= cap)
                begin
                    job.summary.status = STAT_IGN;
                end
                else
                begin
                    job.kind         = JOB_MOVE_L;
                    job.rd_addr      = left_top[ADDR_W-1:0];
                    job.wr_addr      = right_count_reg[ADDR_W-1:0];
                    left_count_next  = left_top;
                    right_count_next = right_count_reg + CNT_W'(1);
                end
            end
            OP_RIGHT:
            begin
                if (right_count_reg == '0 || left_count_reg >= cap)
                begin
                    job.summary.status = STAT_IGN;
                end
                else
                begin
                    job.kind         = JOB_MOVE_R;
                    job.rd_addr      = right_top[ADDR_W-1:0];
                    job.wr_addr      = left_count_reg[ADDR_W-1:0];
                    right_count_next = right_top;
                    left_count_next  = left_count_reg + CNT_W'(1);
                end
            end
            OP_BACK:
            begin
                if (left_count_reg == '0)
                begin
                    job.summary.status = STAT_IGN;
                end
                else
                begin
                    left_count_next = left_top;
                end
            end
            OP_INS:
            begin
                if (len >= cap || left_count_reg >= cap)
                begin
                    job.summary.status = STAT_FULL;
                end
                else
                begin
                    job.kind        = JOB_INSERT;
                    job.wr_addr     = left_count_reg[ADDR_W-1:0];
                    left_count_next = left_count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (idx_ext < left_count_reg)
                begin
                    job.kind    = JOB_READ_L;
                    job.rd_addr = read_index[ADDR_W-1:0];
                end
                else if (idx_ext < len && right_pos < cap)
                begin
                    job.kind    = JOB_READ_R;
                    job.rd_addr = right_pos[ADDR_W-1:0];
                end
                else
                begin
                    job.summary.status = STAT_IGN;
                end
            end
            default:
            begin
                job.summary.status = STAT_IGN;
            end
        endcase
        job.summary.text_length = left_count_next + right_count_next;
        job.summary.cursor_pos  = left_count_next;
    end

    // stack depths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end
        else if (accept)
        begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
        end
    end

endmodule

// File: rtl/core/cleb_back.sv
// stack memories, job sequencer and result queue
module cleb_back
    import cleb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              job_in,
    input  logic              job_empty,
    output logic              job_pop,
    input  logic              pop,
    output logic              empty,
    output logic [CHAR_W-1:0] char_out,
    output logic [CNT_W-1:0]  text_length,
    output logic [CNT_W-1:0]  cursor_pos,
    output logic [STATUS_W-1:0] status
);

    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_EXEC = 1'b1;

    logic              state_reg;
    logic              state_next;
    job_t              job_reg;
    logic [CHAR_W-1:0] left_mem  [CAPACITY];
    logic [CHAR_W-1:0] right_mem [CAPACITY];
    logic [CHAR_W-1:0] left_rdata_reg;
    logic [CHAR_W-1:0] right_rdata_reg;
    logic              start;
    logic              exec;
    logic              left_we;
    logic [CHAR_W-1:0] left_wdata;
    logic              right_we;
    result_t           res_word;

    result_t              res_slot_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_ptr_reg;
    logic [RES_PTR_W-1:0] res_rd_ptr_reg;
    logic [RES_CNT_W-1:0] res_count_reg;
    logic                 res_pop;
    result_t              res_head;

    // job start needs a free result slot; only one job is in flight
    assign start   = (state_reg == BK_IDLE) && !job_empty
                     && (res_count_reg < RES_CNT_W'(RES_DEPTH));
    assign exec    = (state_reg == BK_EXEC);
    assign job_pop = start;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job_in;
        end
    end

    // write side of the stacks
    assign left_we    = exec && (job_reg.kind == JOB_MOVE_R || job_reg.kind == JOB_INSERT);
    assign left_wdata = (job_reg.kind == JOB_MOVE_R) ? right_rdata_reg : job_reg.ch;
    assign right_we   = exec && (job_reg.kind == JOB_MOVE_L);

    // left stack, text order
    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[job_reg.wr_addr] <= left_wdata;
        end
        if (start)
        begin
            left_rdata_reg <= left_mem[job_in.rd_addr];
        end
    end

    // right stack, reverse text order
    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[job_reg.wr_addr] <= left_rdata_reg;
        end
        if (start)
        begin
            right_rdata_reg <= right_mem[job_in.rd_addr];
        end
    end

    // result word
    always_comb
    begin
        res_word.summary = job_reg.summary;
        case (job_reg.kind)
            JOB_READ_L: res_word.char_out = left_rdata_reg;
            JOB_READ_R: res_word.char_out = right_rdata_reg;
            default:    res_word.char_out = '0;
        endcase
    end

    // result queue
    assign empty   = (res_count_reg == '0);
    assign res_pop = pop && !empty;
    assign res_head = res_slot_reg[res_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (exec)
            begin
                res_wr_ptr_reg <= (res_wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1))
                                  ? '0 : res_wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= (res_rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1))
                                  ? '0 : res_rd_ptr_reg + 1'b1;
            end
            if (exec && !res_pop)
            begin
                res_count_reg <= res_count_reg + 1'b1;
            end
            else if (res_pop && !exec)
            begin
                res_count_reg <= res_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_slot_reg[res_wr_ptr_reg] <= res_word;
        end
    end

    assign char_out    = res_head.char_out;
    assign text_length = res_head.summary.text_length;
    assign cursor_pos  = res_head.summary.cursor_pos;
    assign status      = res_head.summary.status;

endmodule

// File: rtl/core/cleb_checker.sv
// port-level checker for the line edit buffer and its bind
`include "cursor_line_edit_buffer_core_assert.svh"

module cleb_checker
    import cleb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [CHAR_W-1:0]   char_out,
    input logic [CNT_W-1:0]    text_length,
    input logic [CNT_W-1:0]    cursor_pos,
    input logic [STATUS_W-1:0] status
);

    // status is one of the three defined codes
    `CLEB_ASSERT_NOW(a_status_code, !empty, status == STAT_DONE || status == STAT_IGN || status == STAT_FULL, "undefined status code")

    // cursor never past the end, length never past capacity
    `CLEB_ASSERT_NOW(a_cursor_in_text, !empty, cursor_pos <= text_length && text_length <= CNT_W'(CAPACITY), "cursor or length out of range")

    // a nonzero byte only comes from a successful read
    `CLEB_ASSERT_NOW(a_char_only_done, !empty && char_out != '0, status == STAT_DONE, "byte on a failed command")

    // a waiting word stays put until taken
    `CLEB_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(char_out) && $stable(status), "result word changed while waiting")

endmodule

bind cursor_line_edit_buffer_core cleb_checker u_cleb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .char_out    (char_out),
    .text_length (text_length),
    .cursor_pos  (cursor_pos),
    .status      (status)
);

// File: tb/cursor_line_edit_buffer_core_tb.sv
// self-checking testbench for the cursor line edit buffer core
`timescale 1ns / 100ps

module cursor_line_edit_buffer_core_tb;
    import cleb_pkg::*;

    // shadow of the gap buffer, predicts one result word per command word
    class edit_scoreboard;
        logic [CHAR_W-1:0] left_chars [CAPACITY];
        logic [CHAR_W-1:0] right_chars [CAPACITY];
        int unsigned left_depth;
        int unsigned right_depth;
        result_t expected_q[$];
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned good_reads;
        int unsigned full_refusals;
        int unsigned boundary_ignores;
        int unsigned peak_length;

        function new();
            left_depth = 0;
            right_depth = 0;
            mismatches = 0;
            words_checked = 0;
            good_reads = 0;
            full_refusals = 0;
            boundary_ignores = 0;
            peak_length = 0;
        endfunction

        // apply one accepted command word to the shadow and queue its result
        function void note_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [INDEX_W-1:0] idx);
            result_t exp_word;
            int unsigned len;
            len = left_depth + right_depth;
            exp_word = '0;
            exp_word.summary.status = STAT_DONE;
            case (op)
                OP_LEFT:
                begin
                    if (left_depth == 0 || right_depth >= CAPACITY)
                        exp_word.summary.status = STAT_IGN;
                    else
                    begin
                        left_depth--;
                        right_chars[right_depth] = left_chars[left_depth];
                        right_depth++;
                    end
                end
                OP_RIGHT:
                begin
                    if (right_depth == 0 || left_depth >= CAPACITY)
                        exp_word.summary.status = STAT_IGN;
                    else
                    begin
                        right_depth--;
                        left_chars[left_depth] = right_chars[right_depth];
                        left_depth++;
                    end
                end
                OP_BACK:
                begin
                    if (left_depth == 0)
                        exp_word.summary.status = STAT_IGN;
                    else
                        left_depth--;
                end
                OP_INS:
                begin
                    if (len >= CAPACITY || left_depth >= CAPACITY)
                        exp_word.summary.status = STAT_FULL;
                    else
                    begin
                        left_chars[left_depth] = ch;
                        left_depth++;
                    end
                end
                OP_READ:
                begin
                    if (idx < left_depth)
                        exp_word.char_out = left_chars[idx];
                    else if (idx < len)
                        exp_word.char_out = right_chars[right_depth - 1 - (idx - left_depth)];
                    else
                        exp_word.summary.status = STAT_IGN;
                    if (exp_word.summary.status == STAT_DONE)
                        good_reads++;
                end
                default:
                    exp_word.summary.status = STAT_IGN;
            endcase
            if (exp_word.summary.status == STAT_IGN)
                boundary_ignores++;
            if (exp_word.summary.status == STAT_FULL)
                full_refusals++;
            exp_word.summary.text_length = CNT_W'(left_depth + right_depth);
            exp_word.summary.cursor_pos = CNT_W'(left_depth);
            if (left_depth + right_depth > peak_length)
                peak_length = left_depth + right_depth;
            expected_q.push_back(exp_word);
        endfunction

        // report one field that differs
        function void match_field(string field, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result word %0d %s mismatch, expected %0d, actual %0d",
                             $time, words_checked, field, exp_val, act_val);
            end
        endfunction

        // compare a popped result word with the oldest prediction
        function void check_result(logic [CHAR_W-1:0] ch, logic [CNT_W-1:0] len,
                                   logic [CNT_W-1:0] cur, logic [STATUS_W-1:0] st);
            result_t exp_word;
            words_checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual char %0d len %0d",
                         $time, ch, len);
                return;
            end
            exp_word = expected_q.pop_front();
            match_field("char_out", 16'(exp_word.char_out), 16'(ch));
            match_field("text_length", 16'(exp_word.summary.text_length), 16'(len));
            match_field("cursor_pos", 16'(exp_word.summary.cursor_pos), 16'(cur));
            match_field("status", 16'(exp_word.summary.status), 16'(st));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [OP_W-1:0]     opcode = '0;
    logic [CHAR_W-1:0]   char_in = '0;
    logic [INDEX_W-1:0]  read_index = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [CHAR_W-1:0]   char_out;
    logic [CNT_W-1:0]    text_length;
    logic [CNT_W-1:0]    cursor_pos;
    logic [STATUS_W-1:0] status;

    edit_scoreboard sb;
    int unsigned    sent_words = 0;
    bit             send_calm = 1'b0;
    bit             take_calm = 1'b0;

    cursor_line_edit_buffer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .char_in     (char_in),
        .read_index  (read_index),
        .empty       (empty),
        .pop         (pop),
        .char_out    (char_out),
        .text_length (text_length),
        .cursor_pos  (cursor_pos),
        .status      (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // drive one command word, starting and ending just after a falling edge
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        if (sent_words % 50 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        char_in <= ch;
        read_index <= idx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_command(op, ch, idx);
        sent_words++;
        @(negedge clk);
    endtask

    // random command mix, reads mostly inside the text
    task automatic issue_mixed(input int count);
        int unsigned r;
        int unsigned len;
        logic [OP_W-1:0] op;
        logic [INDEX_W-1:0] idx;
        for (int k = 0; k < count; k++)
        begin
            len = sb.left_depth + sb.right_depth;
            r = $urandom_range(0, 99);
            if (r < 18)
                op = OP_LEFT;
            else if (r < 36)
                op = OP_RIGHT;
            else if (r < 48)
                op = OP_BACK;
            else if (r < 75)
                op = OP_INS;
            else if (r < 95)
                op = OP_READ;
            else
                op = OP_W'($urandom_range(5, 7));
            r = $urandom_range(0, 9);
            if (len > 0 && r < 7)
                idx = INDEX_W'($urandom_range(0, len - 1));
            else if (r == 7)
                idx = INDEX_W'(len);
            else
                idx = INDEX_W'($urandom);
            send_word(op, CHAR_W'($urandom), idx);
        end
    endtask

    // result side: pop with random stalls
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 50 == 0)
                take_calm = ($urandom_range(0, 3) == 0);
            gap = take_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            sb.check_result(char_out, text_length, cursor_pos, status);
            taken++;
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty buffer edges and unused codes
        send_word(OP_LEFT, 8'h00, '0);
        send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_BACK, 8'h00, '0);
        send_word(OP_READ, 8'h00, 12'd0);
        send_word(OP_READ, 8'h00, 12'hFFF);
        send_word(3'd5, 8'hFF, 12'hFFF);
        send_word(3'd6, 8'h00, '0);
        send_word(3'd7, 8'hFF, 12'hFFF);
        // short text, reads on both sides of the cursor
        send_word(OP_INS, 8'h00, '0);
        send_word(OP_INS, 8'hFF, '0);
        send_word(OP_INS, 8'hA5, '0);
        send_word(OP_READ, 8'h00, 12'd0);
        send_word(OP_READ, 8'h00, 12'd2);
        send_word(OP_READ, 8'h00, 12'd3);
        send_word(OP_LEFT, 8'h00, '0);
        send_word(OP_LEFT, 8'h00, '0);
        send_word(OP_READ, 8'h00, 12'd1);
        send_word(OP_READ, 8'h00, 12'd2);
        send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_BACK, 8'h00, '0);
        send_word(OP_INS, 8'h5A, '0);
        send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_READ, 8'h00, 12'hFFF);

        issue_mixed(850);

        // move the cursor to the end of the text
        while (sb.right_depth > 0)
            send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_INS, 8'hFF, '0);
        send_word(OP_RIGHT, 8'h00, '0);
        send_word(OP_READ, 8'h00, 12'hFFF);
        send_word(OP_READ, 8'h00, 12'd0);

        // walk the cursor home
        while (sb.left_depth > 0)
        begin
            if ($urandom_range(0, 31) == 0)
                send_word(OP_READ, 8'h00, INDEX_W'($urandom));
            send_word(OP_LEFT, 8'h00, '0);
        end
        send_word(OP_LEFT, 8'h00, '0);
        send_word(OP_BACK, 8'h00, '0);
        send_word(OP_INS, 8'h00, '0);
        send_word(OP_READ, 8'h00, 12'd0);
        send_word(OP_READ, 8'h00, 12'hFFF);
        issue_mixed(60);

        // drain outstanding result words
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d command words, %0d result words, peak length %0d",
                 sent_words, sb.words_checked, sb.peak_length);
        $display("good reads %0d, full refusals %0d, ignored at boundary %0d",
                 sb.good_reads, sb.full_refusals, sb.boundary_ignores);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("%0t: timeout with %0d result words outstanding",
                 $time, sb.expected_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
